/* hw/rtl/one_wire_bus_master_unit_defines.svh */
// Assertion helpers for the 1-Wire bus master unit.
// Each macro checks one implication on the rising clock edge.
// Checking is held off while reset is asserted.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owbm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owbm next-cycle check failed");

`endif

/* hw/rtl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the 1-Wire bus master unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

    // Command codes carried by each request item
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_START_RESET = 2'd1;
    localparam logic [1:0] CMD_START_BYTE  = 2'd2;
    localparam logic [1:0] CMD_CLEAR_CRC   = 2'd3;

    // Sequence status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_RLOW  = 4'd1;
    localparam logic [3:0] PH_RREL  = 4'd2;
    localparam logic [3:0] PH_RPRES = 4'd3;
    localparam logic [3:0] PH_RPEND = 4'd4;
    localparam logic [3:0] PH_RTAIL = 4'd5;
    localparam logic [3:0] PH_BSYNC = 4'd6;
    localparam logic [3:0] PH_BSAMP = 4'd7;
    localparam logic [3:0] PH_BREST = 4'd8;
    localparam logic [3:0] PH_BREC  = 4'd9;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_PULSE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_LOW      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_GAP    = 3'd5;

    // Register defaults
    localparam logic [9:0] DEF_RESET_PULSE   = 10'd480;
    localparam logic [9:0] DEF_RELEASE_WAIT  = 10'd5;
    localparam logic [9:0] DEF_SLOT          = 10'd70;
    localparam logic [9:0] DEF_PRESENCE_WAIT = 10'd240;
    localparam logic [7:0] DEF_SYNC_LOW      = 8'd10;
    localparam logic [7:0] DEF_SAMPLE_GAP    = 8'd10;

    // Reflected CRC-8 constants
    localparam logic [7:0] CRC_FOLD = 8'h18;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] LSB_MASK = 8'h01;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
        logic [7:0] crc_value;
        logic       device_found;
    } result_t;

endpackage

/* hw/rtl/owbm_if.sv */
// ----------------------------------------------------------------------------
// owbm_req_if / owbm_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface owbm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, output cmd, output tx_byte, output line_level,
                    input ready);
    modport sink (input valid, input cmd, input tx_byte, input line_level,
                  output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
    logic       device_found;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output rx_byte, output crc_value,
                    output device_found, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input status, input rx_byte, input crc_value, input device_found,
                  output ready);
endinterface

/* hw/rtl/one_wire_bus_master_unit.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire master stepped by one-microsecond tick items, with reset/presence
// detection, LSB-first byte slots and a running CRC-8 over received bytes.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  request   | in  | valid / ready | cmd, tx_byte, line_level
//  result    | out | valid / ready | drive_low, busy_res, done_res, status,
//            |     |               | rx_byte, crc_value, device_found
//  cfg       | in  | cfg_write     | cfg_index, cfg_data (no read-back)
//
//  One item per cycle unless the result stalls: each item is registered,
//  stepped through the sequencer and lands in the result register.
//  A result is valid once its request has passed the input and result regs.
//  A stalled result holds its register; a request is still taken while the
//  result waits, then the input register holds until the result drains.
//  Reset releases the bus, clears the sequencer and restores timing defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_wire_bus_master_unit_defines.svh"

module one_wire_bus_master_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    owbm_req_if.sink                         request,
    owbm_res_if.source                       result,
    input  logic                             cfg_write,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Timing registers
    logic [9:0] reset_pulse_reg, release_wait_reg, slot_reg, presence_wait_reg;
    logic [7:0] sync_low_reg, sample_gap_reg;

    // Input register
    logic       req_valid_reg;
    logic [1:0] req_cmd_reg;
    logic [7:0] req_tx_reg;
    logic       req_lvl_reg;

    // Sequencer state
    logic [3:0] phase_reg, phase_next;
    logic [9:0] wait_reg, wait_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] crc_reg, crc_next;
    logic [1:0] status_reg, status_next;
    logic       found_reg, found_next;
    logic       drive_reg, drive_next;
    logic       done_next;

    // Result register
    logic                res_valid_reg;
    owbm_pkg::result_t   result_reg, result_next;

    logic       advance;
    logic       req_take;
    logic [7:0] crc_base;
    logic [7:0] crc_byte;

    assign advance  = req_valid_reg && (!res_valid_reg || result.ready);
    assign request.ready = !req_valid_reg || advance;
    assign req_take = request.valid && request.ready;
    assign crc_base = (req_cmd_reg == owbm_pkg::CMD_CLEAR_CRC) ? 8'h00 : crc_reg;

    owbm_crc8 u_crc8 (
        .data    (shift_reg),
        .crc_in  (crc_base),
        .crc_out (crc_byte)
    );

    function automatic logic [9:0] arm_count(input logic [9:0] n);
        arm_count = (n == 10'd0) ? 10'd1 : n;
    endfunction

    always_comb
    begin
        logic       fin;
        logic [1:0] fin_st;
        logic [9:0] dec;
        logic [8:0] used;
        logic [9:0] rest;
        logic [9:0] tail;

        fin         = 1'b0;
        fin_st      = owbm_pkg::ST_OK;
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        crc_next    = crc_base;
        status_next = status_reg;
        found_next  = found_reg;
        drive_next  = drive_reg;
        done_next   = 1'b0;

        dec  = (wait_reg != 10'd0) ? (wait_reg - 10'd1) : 10'd0;
        used = {1'b0, sync_low_reg} + {1'b0, sample_gap_reg};
        rest = (slot_reg > {1'b0, used}) ? (slot_reg - {1'b0, used}) : 10'd0;
        tail = (reset_pulse_reg > presence_wait_reg) ?
               (reset_pulse_reg - presence_wait_reg) : 10'd0;

        if (phase_reg == owbm_pkg::PH_IDLE)
        begin
            unique case (req_cmd_reg)
                owbm_pkg::CMD_START_RESET:
                begin
                    if (!req_lvl_reg)
                    begin
                        fin    = 1'b1;
                        fin_st = owbm_pkg::ST_SHORT;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        phase_next = owbm_pkg::PH_RLOW;
                        wait_next  = arm_count(reset_pulse_reg);
                    end
                end
                owbm_pkg::CMD_START_BYTE:
                begin
                    shift_next = req_tx_reg;
                    bit_next   = 3'd0;
                    if (!req_lvl_reg)
                    begin
                        fin    = 1'b1;
                        fin_st = owbm_pkg::ST_SHORT;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        phase_next = owbm_pkg::PH_BSYNC;
                        wait_next  = arm_count({2'b00, sync_low_reg});
                    end
                end
                owbm_pkg::CMD_TICK, owbm_pkg::CMD_CLEAR_CRC:
                begin
                end
            endcase
        end
        else
        begin
            wait_next = dec;
            if (dec == 10'd0)
            begin
                unique case (phase_reg)
                    owbm_pkg::PH_RLOW:
                    begin
                        drive_next = 1'b0;
                        phase_next = owbm_pkg::PH_RREL;
                        wait_next  = arm_count(release_wait_reg);
                    end
                    owbm_pkg::PH_RREL:
                    begin
                        if (!req_lvl_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = owbm_pkg::ST_SHORT;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_RPRES;
                            wait_next  = arm_count(slot_reg);
                        end
                    end
                    owbm_pkg::PH_RPRES:
                    begin
                        if (req_lvl_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = owbm_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_RPEND;
                            wait_next  = arm_count(presence_wait_reg);
                        end
                    end
                    owbm_pkg::PH_RPEND:
                    begin
                        if (!req_lvl_reg)
                        begin
                            fin    = 1'b1;
                            fin_st = owbm_pkg::ST_SHORT;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_RTAIL;
                            wait_next  = arm_count(tail);
                        end
                    end
                    owbm_pkg::PH_RTAIL:
                    begin
                        found_next = 1'b1;
                        fin        = 1'b1;
                        fin_st     = owbm_pkg::ST_OK;
                    end
                    owbm_pkg::PH_BSYNC:
                    begin
                        // release early for a one bit, keep low for a zero
                        if (shift_reg[0])
                        begin
                            drive_next = 1'b0;
                        end
                        shift_next = shift_reg >> 1;
                        phase_next = owbm_pkg::PH_BSAMP;
                        wait_next  = arm_count({2'b00, sample_gap_reg});
                    end
                    owbm_pkg::PH_BSAMP:
                    begin
                        if (req_lvl_reg)
                        begin
                            shift_next = shift_reg | owbm_pkg::CRC_TOP;
                        end
                        phase_next = owbm_pkg::PH_BREST;
                        wait_next  = arm_count(rest);
                    end
                    owbm_pkg::PH_BREST:
                    begin
                        drive_next = 1'b0;
                        phase_next = owbm_pkg::PH_BREC;
                        wait_next  = arm_count({2'b00, sample_gap_reg});
                    end
                    owbm_pkg::PH_BREC:
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            crc_next = crc_byte;
                            fin      = 1'b1;
                            fin_st   = owbm_pkg::ST_OK;
                        end
                        else
                        begin
                            bit_next = bit_reg + 3'd1;
                            if (!req_lvl_reg)
                            begin
                                fin    = 1'b1;
                                fin_st = owbm_pkg::ST_SHORT;
                            end
                            else
                            begin
                                drive_next = 1'b1;
                                phase_next = owbm_pkg::PH_BSYNC;
                                wait_next  = arm_count({2'b00, sync_low_reg});
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        wait_next  = 10'd0;
                        drive_next = 1'b0;
                    end
                endcase
            end
        end

        // end of sequence: back to idle with the bus released
        if (fin)
        begin
            status_next = fin_st;
            phase_next  = owbm_pkg::PH_IDLE;
            wait_next   = 10'd0;
            bit_next    = 3'd0;
            drive_next  = 1'b0;
            done_next   = 1'b1;
        end

        result_next.drive_low    = drive_next;
        result_next.busy_res     = (phase_next != owbm_pkg::PH_IDLE);
        result_next.done_res     = done_next;
        result_next.status       = status_next;
        result_next.rx_byte      = shift_next;
        result_next.crc_value    = crc_next;
        result_next.device_found = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_pulse_reg   <= owbm_pkg::DEF_RESET_PULSE;
            release_wait_reg  <= owbm_pkg::DEF_RELEASE_WAIT;
            slot_reg          <= owbm_pkg::DEF_SLOT;
            presence_wait_reg <= owbm_pkg::DEF_PRESENCE_WAIT;
            sync_low_reg      <= owbm_pkg::DEF_SYNC_LOW;
            sample_gap_reg    <= owbm_pkg::DEF_SAMPLE_GAP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                owbm_pkg::CFG_RESET_PULSE:   reset_pulse_reg   <= cfg_data;
                owbm_pkg::CFG_RELEASE_WAIT:  release_wait_reg  <= cfg_data;
                owbm_pkg::CFG_SLOT:          slot_reg          <= cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT: presence_wait_reg <= cfg_data;
                owbm_pkg::CFG_SYNC_LOW:      sync_low_reg      <= cfg_data[7:0];
                owbm_pkg::CFG_SAMPLE_GAP:    sample_gap_reg    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= owbm_pkg::PH_IDLE;
            wait_reg      <= 10'd0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'h00;
            crc_reg       <= 8'h00;
            status_reg    <= owbm_pkg::ST_OK;
            found_reg     <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else
        begin
            if (req_take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                wait_reg      <= wait_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                crc_reg       <= crc_next;
                status_reg    <= status_next;
                found_reg     <= found_next;
                drive_reg     <= drive_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: loaded with no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_cmd_reg <= request.cmd;
            req_tx_reg  <= request.tx_byte;
            req_lvl_reg <= request.line_level;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.drive_low    = result_reg.drive_low;
    assign result.busy_res     = result_reg.busy_res;
    assign result.done_res     = result_reg.done_res;
    assign result.status       = result_reg.status;
    assign result.rx_byte      = result_reg.rx_byte;
    assign result.crc_value    = result_reg.crc_value;
    assign result.device_found = result_reg.device_found;

    `OWBM_ASSERT_NOW(a_idle_released, clk, rst_n, phase_reg == owbm_pkg::PH_IDLE, !drive_reg)
    `OWBM_ASSERT_NOW(a_busy_counting, clk, rst_n, phase_reg != owbm_pkg::PH_IDLE, wait_reg != 10'd0)
    `OWBM_ASSERT_NOW(a_done_not_busy, clk, rst_n, res_valid_reg && result_reg.done_res, !result_reg.busy_res)
    `OWBM_ASSERT_NOW(a_status_legal, clk, rst_n, 1'b1, status_reg != 2'd3)
    `OWBM_ASSERT_NEXT(a_input_held, clk, rst_n, req_valid_reg && !advance, req_valid_reg)

endmodule

/* hw/rtl/owbm_crc8.sv */
// ----------------------------------------------------------------------------
// owbm_crc8
// One-byte update of the reflected Dallas/Maxim CRC-8, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_crc8 (
    input  logic [7:0] data,
    input  logic [7:0] crc_in,
    output logic [7:0] crc_out
);

    always_comb
    begin
        logic [7:0] d;
        logic [7:0] c;
        d = data;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            if (((d ^ c) & owbm_pkg::LSB_MASK) != 8'h00)
            begin
                c = ((c ^ owbm_pkg::CRC_FOLD) >> 1) | owbm_pkg::CRC_TOP;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        crc_out = c;
    end

endmodule
